[hdl/bdl_pkg.sv]
// Shared constants and types for the button debouncer with encoder long-press detection.
package bdl_pkg;

  // Width of each configuration register and of the configuration write data.
  localparam int unsigned CFG_DATA_W = 16;
  // Two registers, so one index bit covers the whole register list.
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_DEBOUNCE   = 1'b0;
  localparam cfg_idx_t CFG_LONG_PRESS = 1'b1;

  localparam cfg_data_t DEBOUNCE_RESET   = 16'd50;
  localparam cfg_data_t LONG_PRESS_RESET = 16'd700;

  // Buttons with an index below this report navigation events.
  localparam int unsigned NAV_LIMIT = 4;

  typedef logic signed [2:0] nav_t;
  localparam nav_t NAV_NONE = 3'sb111;

  typedef struct packed {
    nav_t nav_button;
    logic encoder_short_press;
    logic encoder_long_press;
    logic encoder_held;
  } result_t;

endpackage

[hdl/bdl_ifs.sv]
// Valid/ready channel interfaces for the poll input and the result output.
interface bdl_in_if #(
  parameter int unsigned NUM_BUTTONS = 5,
  parameter int unsigned TIME_BITS   = 32
);
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] button_levels;
  logic [TIME_BITS-1:0]   now_ms;

  modport source (output valid, output button_levels, output now_ms, input ready);
  modport sink   (input valid, input button_levels, input now_ms, output ready);
endinterface

interface bdl_out_if;
  logic              valid;
  logic              ready;
  logic signed [2:0] nav_button;
  logic              encoder_short_press;
  logic              encoder_long_press;
  logic              encoder_held;

  modport source (output valid, output nav_button, output encoder_short_press,
                  output encoder_long_press, output encoder_held, input ready);
  modport sink   (input valid, input nav_button, input encoder_short_press,
                  input encoder_long_press, input encoder_held, output ready);
endinterface

[hdl/bdl_in_reg.sv]
// Input register stage that captures one poll beat and holds it until the evaluator takes it.
module bdl_in_reg #(
  parameter int unsigned NUM_BUTTONS = 5,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [NUM_BUTTONS-1:0] up_levels,
  input  logic [TIME_BITS-1:0]   up_now,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [NUM_BUTTONS-1:0] dn_levels,
  output logic [TIME_BITS-1:0]   dn_now
);

  logic                   valid_r, valid_nxt;
  logic [NUM_BUTTONS-1:0] levels_r;
  logic [TIME_BITS-1:0]   now_r;
  logic                   load;

  // The slot is free when empty or when its beat leaves in this cycle.
  assign up_ready  = !valid_r || dn_ready;
  assign load      = up_valid && up_ready;
  assign valid_nxt = load ? 1'b1 : (dn_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      levels_r <= up_levels;
      now_r    <= up_now;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_levels = levels_r;
  assign dn_now    = now_r;

endmodule

[hdl/bdl_core.sv]
// Debounce state, per-poll evaluation and the result register.
module bdl_core
  import bdl_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 5,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_data_t              debounce_ms,
  input  cfg_data_t              long_press_ms,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [NUM_BUTTONS-1:0] in_levels,
  input  logic [TIME_BITS-1:0]   in_now,
  output logic                   res_valid,
  input  logic                   res_ready,
  output result_t                res
);

  localparam int unsigned ENC_IDX = NUM_BUTTONS - 1;

  typedef logic [TIME_BITS-1:0] time_t;

  logic [NUM_BUTTONS-1:0] prior_raw_r, prior_raw_nxt;
  logic [NUM_BUTTONS-1:0] qual_r, qual_nxt;
  time_t                  chg_time_r [NUM_BUTTONS];
  time_t                  chg_time_nxt [NUM_BUTTONS];
  time_t                  press_time_r, press_time_nxt;
  logic                   long_done_r, long_done_nxt;
  logic                   res_valid_r, res_valid_nxt;
  result_t                res_r, res_nxt;
  logic                   take;

  // Evaluate whenever the result slot is free, so one poll per cycle flows through.
  assign in_ready = !res_valid_r || res_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    logic [NUM_BUTTONS-1:0] stable_ok;
    logic [NUM_BUTTONS-1:0] flip;
    time_t                  deb_ext;
    time_t                  long_ext;
    time_t                  held_old;
    logic                   enc_press;
    logic                   enc_release;
    logic                   ld_eff;
    logic                   long_hit;

    deb_ext  = TIME_BITS'(debounce_ms);
    long_ext = TIME_BITS'(long_press_ms);
    res_nxt.nav_button = NAV_NONE;

    for (int i = 0; i < NUM_BUTTONS; i++) begin
      // A raw change restarts the timer at now, so the elapsed time is zero.
      stable_ok[i] = (in_levels[i] == prior_raw_r[i]) &&
                     ((in_now - chg_time_r[i]) > deb_ext);
      flip[i]          = stable_ok[i] && (in_levels[i] != qual_r[i]);
      qual_nxt[i]      = flip[i] ? in_levels[i] : qual_r[i];
      chg_time_nxt[i]  = (in_levels[i] != prior_raw_r[i]) ? in_now : chg_time_r[i];
      prior_raw_nxt[i] = in_levels[i];
    end

    // Ascending scan so the highest pressed navigation button wins.
    for (int i = 0; i < NUM_BUTTONS - 1; i++) begin
      if ((i < NAV_LIMIT) && flip[i] && !in_levels[i]) begin
        res_nxt.nav_button = nav_t'(i);
      end
    end

    enc_press   = flip[ENC_IDX] && !in_levels[ENC_IDX];
    enc_release = flip[ENC_IDX] && in_levels[ENC_IDX];
    held_old    = in_now - press_time_r;

    res_nxt.encoder_short_press = enc_release && !long_done_r && (held_old >= deb_ext);

    // A press in this poll restarts the hold time at zero.
    ld_eff   = enc_press ? 1'b0 : long_done_r;
    long_hit = enc_press ? (long_press_ms == '0) : (held_old >= long_ext);
    res_nxt.encoder_long_press = stable_ok[ENC_IDX] && !qual_nxt[ENC_IDX] && !ld_eff &&
                                 long_hit;
    res_nxt.encoder_held = !qual_nxt[ENC_IDX];

    long_done_nxt  = res_nxt.encoder_long_press ? 1'b1 : ld_eff;
    press_time_nxt = enc_press ? in_now : press_time_r;
  end

  assign res_valid_nxt = take ? 1'b1 : (res_ready ? 1'b0 : res_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r  <= 1'b0;
      prior_raw_r  <= '1;
      qual_r       <= '1;
      press_time_r <= '0;
      long_done_r  <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        chg_time_r[i] <= '0;
      end
    end else begin
      res_valid_r <= res_valid_nxt;
      if (take) begin
        prior_raw_r  <= prior_raw_nxt;
        qual_r       <= qual_nxt;
        press_time_r <= press_time_nxt;
        long_done_r  <= long_done_nxt;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          chg_time_r[i] <= chg_time_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[hdl/button_debounce_long_press.sv]
// Top level of the five-button debouncer with encoder short and long press reporting.
//
// Each input beat is one poll: the raw active-low level of every button and the current
// millisecond time; each poll yields exactly one result beat. A poll is accepted in every
// cycle while results are taken, so the sustained rate is one beat per clock. A poll is
// evaluated while it sits in the input register and is written into the result register
// when the core takes it, which it does whenever the result slot is free; its result beat
// then stays offered, with its payload held, until the output side takes it. The rate is
// set by the single evaluation stage, which reads and updates the per-button timers,
// qualified levels and the encoder press time in the same cycle. A button takes a new
// level once its raw level has been unchanged for more than debounce_ms; a new press on
// buttons 0 to 3 reports its index (the highest wins), and the last button reports a
// short press on release or a single long press after long_press_ms of hold. Timer
// arithmetic wraps modulo 2^TIME_BITS. Configuration writes take effect on the next
// clock and are meant to happen only while no poll is in flight. There is no clearing
// pass after reset: the block takes polls from the first cycle after reset is released.
module button_debounce_long_press
  import bdl_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 5,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  bdl_in_if.sink           in_bus,
  bdl_out_if.source        out_bus,
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_index,
  input  cfg_data_t        cfg_wdata
);

  cfg_data_t debounce_r, debounce_nxt;
  cfg_data_t long_press_r, long_press_nxt;

  logic                   s1_valid;
  logic                   s1_ready;
  logic [NUM_BUTTONS-1:0] s1_levels;
  logic [TIME_BITS-1:0]   s1_now;
  result_t                res;

  // Configuration registers: written by index, no read-back.
  always_comb begin
    debounce_nxt   = debounce_r;
    long_press_nxt = long_press_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_nxt   = cfg_wdata;
        CFG_LONG_PRESS: long_press_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else begin
      debounce_r   <= debounce_nxt;
      long_press_r <= long_press_nxt;
    end
  end

  // The input register decouples the poll channel from the evaluation stage.
  bdl_in_reg #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_bus.valid),
    .up_ready  (in_bus.ready),
    .up_levels (in_bus.button_levels),
    .up_now    (in_bus.now_ms),
    .dn_valid  (s1_valid),
    .dn_ready  (s1_ready),
    .dn_levels (s1_levels),
    .dn_now    (s1_now)
  );

  // The core holds all debounce state and registers the result beat.
  bdl_core #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .debounce_ms   (debounce_r),
    .long_press_ms (long_press_r),
    .in_valid      (s1_valid),
    .in_ready      (s1_ready),
    .in_levels     (s1_levels),
    .in_now        (s1_now),
    .res_valid     (out_bus.valid),
    .res_ready     (out_bus.ready),
    .res           (res)
  );

  assign out_bus.nav_button          = res.nav_button;
  assign out_bus.encoder_short_press = res.encoder_short_press;
  assign out_bus.encoder_long_press  = res.encoder_long_press;
  assign out_bus.encoder_held        = res.encoder_held;

endmodule

[hdl/bdl_checker.sv]
// Port-level assertions for the debouncer top level and the bind that attaches them.
module bdl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_nav,
  input logic       out_short,
  input logic       out_long,
  input logic       out_held
);

  // A stalled result beat stays offered.
  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_nav) && $stable(out_short) && $stable(out_long) && $stable(out_held))
    else $error("result payload changed while stalled");

  // Only navigation buttons 0 to 3 or none can be reported.
  a_nav_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nav == 3'b111) || !out_nav[2])
    else $error("navigation index out of range");

  // A long press is reported only while the encoder is held.
  a_long_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_long |-> out_held)
    else $error("long press without held encoder");

  // A short press comes with a release, never together with a long press.
  a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short |-> !out_held && !out_long)
    else $error("short press while encoder held");

endmodule

bind button_debounce_long_press bdl_checker u_bdl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_nav   (out_bus.nav_button),
  .out_short (out_bus.encoder_short_press),
  .out_long  (out_bus.encoder_long_press),
  .out_held  (out_bus.encoder_held)
);

[dv/button_debounce_long_press_tb.sv]
// Self-checking testbench for the five-button debouncer with encoder long-press detection.

class press_scoreboard;
  localparam int ENC = 4;

  bdl_pkg::cfg_data_t debounce_ms;
  bdl_pkg::cfg_data_t long_press_ms;
  logic [4:0]         last_raw;
  logic [4:0]         settled;
  logic [31:0]        changed_at [5];
  logic [31:0]        press_start;
  bit                 long_sent;
  bdl_pkg::result_t   expected_events [$];
  int unsigned        mismatches;

  function new();
    debounce_ms   = bdl_pkg::DEBOUNCE_RESET;
    long_press_ms = bdl_pkg::LONG_PRESS_RESET;
    last_raw      = '1;
    settled       = '1;
    foreach (changed_at[i]) changed_at[i] = '0;
    press_start   = '0;
    long_sent     = 1'b0;
    mismatches    = 0;
  endfunction

  function void write_reg(bdl_pkg::cfg_idx_t idx, bdl_pkg::cfg_data_t value);
    case (idx)
      bdl_pkg::CFG_DEBOUNCE:   debounce_ms = value;
      bdl_pkg::CFG_LONG_PRESS: long_press_ms = value;
      default: ;
    endcase
  endfunction

  // Advances the button state by one poll and queues the event it should produce.
  function void note_poll(logic [4:0] levels, logic [31:0] now);
    bdl_pkg::result_t ev;
    logic [31:0]      stable;
    logic [31:0]      held;
    logic             raw;
    ev.nav_button          = bdl_pkg::NAV_NONE;
    ev.encoder_short_press = 1'b0;
    ev.encoder_long_press  = 1'b0;
    for (int i = 0; i < 5; i++) begin
      raw = levels[i];
      if (raw != last_raw[i]) changed_at[i] = now;
      stable = now - changed_at[i];
      if (stable > {16'd0, debounce_ms}) begin
        if (raw != settled[i]) begin
          settled[i] = raw;
          held = now - press_start;
          if (!raw) begin
            if (i == ENC) begin
              press_start = now;
              long_sent   = 1'b0;
            end else if (i < int'(bdl_pkg::NAV_LIMIT)) begin
              ev.nav_button = bdl_pkg::nav_t'(i);
            end
          end else if (i == ENC && !long_sent && held >= {16'd0, debounce_ms}) begin
            ev.encoder_short_press = 1'b1;
          end
        end
        if (i == ENC && !settled[i] && !long_sent) begin
          held = now - press_start;
          if (held >= {16'd0, long_press_ms}) begin
            ev.encoder_long_press = 1'b1;
            long_sent             = 1'b1;
          end
        end
      end
      last_raw[i] = raw;
    end
    ev.encoder_held = !settled[ENC];
    expected_events.push_back(ev);
  endfunction

  function void compare_field(string field, logic signed [2:0] want, logic signed [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function void check_event(bdl_pkg::result_t got);
    bdl_pkg::result_t want;
    if (expected_events.size() == 0) begin
      $error("result beat arrived with no poll outstanding");
      mismatches++;
      return;
    end
    want = expected_events.pop_front();
    compare_field("nav_button", want.nav_button, got.nav_button);
    compare_field("encoder_short_press", want.encoder_short_press, got.encoder_short_press);
    compare_field("encoder_long_press", want.encoder_long_press, got.encoder_long_press);
    compare_field("encoder_held", want.encoder_held, got.encoder_held);
  endfunction

  function void report_leftovers();
    if (expected_events.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_events.size());
      mismatches += expected_events.size();
    end
  endfunction
endclass

module button_debounce_long_press_tb;
  import bdl_pkg::*;

  // This bound on the run only catches a hang.
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned PHASE_POLLS     = 255;

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  bdl_in_if #(.NUM_BUTTONS(5), .TIME_BITS(32)) in_bus ();
  bdl_out_if out_bus ();

  button_debounce_long_press dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  press_scoreboard sb = new();

  // Stimulus bookkeeping: the current raw levels and wall time that the polls follow.
  logic [4:0]  lvl_now;
  logic [31:0] ms_now;
  int unsigned cur_debounce;
  int unsigned cur_long;
  int unsigned polls_sent;
  int unsigned cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off_armed;
  bit          hold_off_done;
  bit          paused;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hang guard. It never fires in a healthy run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("button_debounce_long_press test failed");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off that lets the block fill up
  // and push back on its input while the sender keeps offering polls.
  initial begin
    out_bus.ready <= 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_armed && !hold_off_done) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every accepted poll goes to the predictor at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_poll(in_bus.button_levels, in_bus.now_ms);
  end

  always @(posedge clk) begin : result_monitor
    result_t beat;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      beat.nav_button          = out_bus.nav_button;
      beat.encoder_short_press = out_bus.encoder_short_press;
      beat.encoder_long_press  = out_bus.encoder_long_press;
      beat.encoder_held        = out_bus.encoder_held;
      sb.check_event(beat);
    end
  end

  // Offers one poll, with random idle cycles ahead of it, and returns at the edge that
  // accepts the beat. Valid stays high so the next poll can follow back to back.
  task automatic poll_at(input logic [4:0] lv, input logic [31:0] stamp);
    lvl_now = lv;
    ms_now  = stamp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.button_levels <= lv;
    in_bus.now_ms        <= stamp;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    polls_sent++;
  endtask

  task automatic advance(input logic [4:0] lv, input logic [31:0] dt);
    poll_at(lv, ms_now + dt);
  endtask

  // Holds the current levels for a span of milliseconds, spread over a few polls so that
  // qualification lands on varying polls within the span.
  task automatic settle(input int unsigned span, input int unsigned max_polls);
    int unsigned k;
    logic [31:0] base;
    k    = $urandom_range(1, max_polls);
    base = ms_now;
    for (int unsigned j = 1; j <= k; j++) poll_at(lvl_now, base + (span * j) / k);
  endtask

  // Contact bounce: the masked buttons flicker at random, each step at most half a debounce time apart.
  task automatic bounce(input logic [4:0] mask);
    repeat ($urandom_range(3)) advance(lvl_now ^ (mask & 5'($urandom)),
                                       $urandom_range(0, cur_debounce / 2));
  endtask

  // One press and release of a button or a group of buttons, with bounce on both edges and
  // hold times chosen around the debounce and long-press thresholds.
  task automatic press_episode();
    logic [4:0] mask;
    case ($urandom_range(9))
      0, 1, 2, 3: mask = 5'b00001 << $urandom_range(3);
      4, 5, 6:    mask = 5'b10000;
      7:          mask = (5'b00001 << $urandom_range(3)) | (5'b00001 << $urandom_range(3));
      8:          mask = 5'b10000 | (5'b00001 << $urandom_range(3));
      default:    mask = 5'($urandom_range(1, 31));
    endcase
    bounce(mask);
    advance(lvl_now & ~mask, $urandom_range(0, cur_debounce / 2));
    case ($urandom_range(5))
      0: settle($urandom_range(0, cur_debounce), 3);
      1: settle(cur_debounce + 1, 2);
      2: settle(cur_debounce + 1 + $urandom_range(0, cur_long), 5);
      3: begin
        // Qualify on a single poll, then land right on or just short of the threshold.
        settle(cur_debounce + 1, 1);
        settle(cur_long - ((cur_long > 0) ? $urandom_range(1) : 0), 3);
      end
      default: settle(cur_debounce + cur_long + $urandom_range(1, 400), 5);
    endcase
    bounce(mask);
    advance(lvl_now | mask, $urandom_range(0, cur_debounce / 2));
    if ($urandom_range(4) == 0) settle($urandom_range(0, cur_debounce), 2);
    else settle(cur_debounce + 1 + $urandom_range(0, 60), 4);
  endtask

  // Unstructured polls: random levels with small steps, arbitrary jumps and time going back.
  task automatic noise_poll();
    logic [4:0] lv;
    lv = 5'($urandom);
    case ($urandom_range(2))
      0:       advance(lv, $urandom_range(0, cur_debounce + 2));
      1:       poll_at(lv, $urandom);
      default: advance(lv, 32'd0 - $urandom_range(1, cur_debounce + 2));
    endcase
  endtask

  // Stops offering polls until every expected result beat has been taken. The first edge
  // lets the input monitor record the last accepted poll before the queue is looked at.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges with the enable held high throughout.
  task automatic program_regs(input cfg_data_t deb, input cfg_data_t lp);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    sb.write_reg(CFG_DEBOUNCE, deb);
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    sb.write_reg(CFG_LONG_PRESS, lp);
    cfg_wr_en <= 1'b0;
    cur_debounce = deb;
    cur_long     = lp;
  endtask

  initial begin
    cfg_data_t   deb;
    cfg_data_t   lp;
    int unsigned goal;
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= CFG_DEBOUNCE;
    cfg_wdata            <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.button_levels <= '1;
    in_bus.now_ms        <= '0;
    lvl_now        = '1;
    ms_now         = '0;
    cur_debounce   = DEBOUNCE_RESET;
    cur_long       = LONG_PRESS_RESET;
    polls_sent     = 0;
    hold_off_armed = 1'b0;
    paused         = 1'b0;
    send_idle_pct  = 32;
    recv_idle_pct  = 55;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed polls under the reset thresholds (50 ms debounce, 700 ms long press).
    poll_at(5'b11111, 32'd100);
    // Buttons 0 and 3 pressed together: exactly the debounce time is not enough, one more
    // millisecond qualifies both and the higher index is reported.
    poll_at(5'b10110, 32'd200);
    poll_at(5'b10110, 32'd250);
    poll_at(5'b10110, 32'd251);
    // Swap to buttons 1 and 2 in the same poll; button 2 wins when they qualify.
    poll_at(5'b11001, 32'd260);
    poll_at(5'b11001, 32'd311);
    poll_at(5'b11111, 32'd320);
    poll_at(5'b11111, 32'd371);
    // Encoder press with a bounce while held, then a long press at exactly 700 ms of hold.
    poll_at(5'b01111, 32'd500);
    poll_at(5'b01111, 32'd551);
    poll_at(5'b11111, 32'd580);
    poll_at(5'b01111, 32'd590);
    poll_at(5'b01111, 32'd641);
    poll_at(5'b01111, 32'd1250);
    poll_at(5'b01111, 32'd1251);
    poll_at(5'b01111, 32'd1400);
    // Release after a long press reports no short press.
    poll_at(5'b11111, 32'd1500);
    poll_at(5'b11111, 32'd1551);
    // Time steps backward before the release, so the hold comes out shorter than the
    // debounce time and the release reports nothing.
    poll_at(5'b01111, 32'd2000);
    poll_at(5'b01111, 32'd2051);
    poll_at(5'b11111, 32'd2040);
    poll_at(5'b11111, 32'd2091);
    // A short press whose timing straddles the wrap of the millisecond counter.
    poll_at(5'b01111, 32'hFFFF_FFF0);
    poll_at(5'b01111, 32'h0000_0023);
    poll_at(5'b11111, 32'h0000_0030);
    poll_at(5'b11111, 32'h0000_0063);

    // Random phases, each under its own thresholds. The register extremes come first,
    // then a random setting and finally the reset values again. Idling moves from a slow
    // sender and slower receiver, to the reverse, to full speed on both sides.
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: begin deb = 16'd0;     lp = 16'd0;     send_idle_pct = 32; recv_idle_pct = 55; end
        1: begin deb = 16'hFFFF;  lp = 16'hFFFF;  send_idle_pct = 32; recv_idle_pct = 55; end
        2: begin deb = 16'd0;     lp = 16'hFFFF;  send_idle_pct = 55; recv_idle_pct = 32; end
        3: begin deb = 16'hFFFF;  lp = 16'd0;     send_idle_pct = 55; recv_idle_pct = 32; end
        4: begin
          deb = 16'($urandom_range(1, 300));
          lp  = 16'($urandom_range(0, 3000));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        default: begin
          deb = DEBOUNCE_RESET;
          lp  = LONG_PRESS_RESET;
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      program_regs(deb, lp);
      // Start the long-threshold phase just below the counter wrap.
      ms_now = (phase == 1) ? 32'hFFFF_8000 : 32'($urandom);
      // The receiver's long hold-off runs at full sender speed so the block backs up.
      if (phase == 4) hold_off_armed = 1'b1;
      goal = polls_sent + PHASE_POLLS;
      while (polls_sent < goal) begin
        // Halfway through one phase the sender goes quiet until the block has drained.
        if (phase == 2 && !paused && polls_sent + PHASE_POLLS / 2 >= goal) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(9) < 8) press_episode();
        else repeat ($urandom_range(1, 4)) noise_poll();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    sb.report_leftovers();
    if (sb.mismatches == 0) begin
      $display("button_debounce_long_press test passed");
    end else begin
      $display("button_debounce_long_press test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bdl_pkg.sv
hdl/bdl_ifs.sv
hdl/bdl_in_reg.sv
hdl/bdl_core.sv
hdl/button_debounce_long_press.sv
hdl/bdl_checker.sv
dv/button_debounce_long_press_tb.sv
